// ===== sv/nhn_pkg.sv =====
// Package for the Hamming number generator: table size and derived widths.
// No dependencies; used by the channel interfaces and the top level.
package nhn_pkg;

  localparam int MAX_N   = 1024;
  localparam int ADDR_W  = $clog2(MAX_N);
  localparam int CNT_W   = $clog2(MAX_N + 1);
  localparam int INDEX_W = 11;
  localparam int VALUE_W = 32;
  // room for value * 5 without wrap
  localparam int CAND_W  = VALUE_W + 3;

endpackage

// ===== sv/nhn_index_if.sv =====
// Request channel: valid/ready handshake carrying the wanted position.
// Depends on nhn_pkg.
interface nhn_index_if;
  logic                        valid;
  logic                        ready;
  logic [nhn_pkg::INDEX_W-1:0] index;

  modport source (output valid, output index, input ready);
  modport sink (input valid, input index, output ready);
endinterface

// ===== sv/nhn_value_if.sv =====
// Response channel: valid/ready handshake carrying the Hamming number.
// Depends on nhn_pkg.
interface nhn_value_if;
  logic                        valid;
  logic                        ready;
  logic [nhn_pkg::VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

// ===== sv/nth_hamming_number_generator.sv =====
// Top level of the Hamming number generator: sequencer plus table memory.
// Depends on nhn_pkg, nhn_index_if and nhn_value_if.
//
// Returns the nth 5-smooth number (1, 2, 3, 4, 5, 6, 8, ...) for a request
// index n, where 1 gives 1, 0 is taken as 1 and anything above MAX_N (1024)
// saturates to MAX_N. The numbers live in a single-port-read, single-port-write
// table memory (MAX_N x 32, registered read) that is kept across requests and
// only grows: a request appends entries only until the table holds n of them,
// so later requests for smaller or equal n are answered straight from the
// table. Appending one entry runs through a check, three reads of the pointer
// entries through the one read port, and the compare/write step. A request
// that finds the table already filled far enough goes from the check straight
// to reading the answer slot. One request is in work at a time; a new request
// is taken as soon as the previous result has been loaded into the output
// register, even while that result still waits to be taken. No clearing pass
// is needed after reset: the fill count alone marks which entries are valid.
module nth_hamming_number_generator (
  input  logic        clk,
  input  logic        rst,
  nhn_index_if.sink   req,
  nhn_value_if.source rsp
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_RD2   = 3'd2;
  localparam logic [2:0] S_RD3   = 3'd3;
  localparam logic [2:0] S_RD5   = 3'd4;
  localparam logic [2:0] S_APP   = 3'd5;
  localparam logic [2:0] S_RES   = 3'd6;

  // table memory
  logic [nhn_pkg::VALUE_W-1:0] table_mem [nhn_pkg::MAX_N];
  logic [nhn_pkg::VALUE_W-1:0] rdata;
  logic [nhn_pkg::ADDR_W-1:0]  raddr;
  logic                        we;
  logic [nhn_pkg::ADDR_W-1:0]  waddr;
  logic [nhn_pkg::VALUE_W-1:0] wdata;

  // control state
  logic [2:0]                  state;
  logic [nhn_pkg::ADDR_W-1:0]  ptr_two;
  logic [nhn_pkg::ADDR_W-1:0]  ptr_three;
  logic [nhn_pkg::ADDR_W-1:0]  ptr_five;
  logic [nhn_pkg::CNT_W-1:0]   fill_count;
  logic [nhn_pkg::CNT_W-1:0]   n_req;
  logic                        out_valid;

  // payload
  logic [nhn_pkg::VALUE_W-1:0] val_two;
  logic [nhn_pkg::VALUE_W-1:0] val_three;
  logic [nhn_pkg::VALUE_W-1:0] out_value;

  logic                        in_xfer;
  logic                        out_free;
  logic [nhn_pkg::CNT_W-1:0]   n_sat;
  logic [nhn_pkg::CNT_W-1:0]   n_last;
  logic [nhn_pkg::CAND_W-1:0]  cand_two;
  logic [nhn_pkg::CAND_W-1:0]  cand_three;
  logic [nhn_pkg::CAND_W-1:0]  cand_five;
  logic [nhn_pkg::CAND_W-1:0]  cand_min23;
  logic [nhn_pkg::CAND_W-1:0]  cand_min;

  // hold off requests while reset is applied
  assign req.ready = (state == S_IDLE) && !rst;
  assign in_xfer   = req.valid && req.ready;
  assign rsp.valid = out_valid;
  assign rsp.value = out_value;
  assign out_free  = !out_valid || rsp.ready;

  // Clamp the request index into 1..MAX_N.
  always_comb begin
    if (req.index == '0) begin
      n_sat = nhn_pkg::CNT_W'(1);
    end else if (req.index > nhn_pkg::INDEX_W'(nhn_pkg::MAX_N)) begin
      n_sat = nhn_pkg::CNT_W'(nhn_pkg::MAX_N);
    end else begin
      n_sat = nhn_pkg::CNT_W'(req.index);
    end
  end

  assign n_last = n_req - nhn_pkg::CNT_W'(1);

  // Candidates: the fifth-pointer entry arrives straight from the read port.
  assign cand_two   = nhn_pkg::CAND_W'(val_two) << 1;
  assign cand_three = (nhn_pkg::CAND_W'(val_three) << 1) + nhn_pkg::CAND_W'(val_three);
  assign cand_five  = (nhn_pkg::CAND_W'(rdata) << 2) + nhn_pkg::CAND_W'(rdata);
  assign cand_min23 = (cand_two < cand_three) ? cand_two : cand_three;
  assign cand_min   = (cand_min23 < cand_five) ? cand_min23 : cand_five;

  // Read address: one pointer per read state, else the answer slot.
  always_comb begin
    case (state)
      S_RD2:   raddr = ptr_two;
      S_RD3:   raddr = ptr_three;
      S_RD5:   raddr = ptr_five;
      default: raddr = n_last[nhn_pkg::ADDR_W-1:0];
    endcase
  end

  // Write port: seed entry on the first request, append in S_APP.
  always_comb begin
    we    = 1'b0;
    waddr = fill_count[nhn_pkg::ADDR_W-1:0];
    wdata = cand_min[nhn_pkg::VALUE_W-1:0];
    if (in_xfer && fill_count == '0) begin
      we    = 1'b1;
      waddr = '0;
      wdata = nhn_pkg::VALUE_W'(1);
    end else if (state == S_APP) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      table_mem[waddr] <= wdata;
    end
    rdata <= table_mem[raddr];
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ptr_two    <= '0;
      ptr_three  <= '0;
      ptr_five   <= '0;
      fill_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      // load a new result, else drop the one just taken
      if (state == S_RES && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            if (fill_count == '0) begin
              fill_count <= nhn_pkg::CNT_W'(1);
              ptr_two    <= '0;
              ptr_three  <= '0;
              ptr_five   <= '0;
            end
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          // advance the table or go read the answer slot
          state <= (fill_count < n_req) ? S_RD2 : S_RES;
        end
        S_RD2: state <= S_RD3;
        S_RD3: state <= S_RD5;
        S_RD5: state <= S_APP;
        S_APP: begin
          fill_count <= fill_count + nhn_pkg::CNT_W'(1);
          if (cand_min == cand_two) begin
            ptr_two <= ptr_two + nhn_pkg::ADDR_W'(1);
          end
          if (cand_min == cand_three) begin
            ptr_three <= ptr_three + nhn_pkg::ADDR_W'(1);
          end
          if (cand_min == cand_five) begin
            ptr_five <= ptr_five + nhn_pkg::ADDR_W'(1);
          end
          state <= S_CHECK;
        end
        S_RES: begin
          // hold the result until the output register is free
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      n_req <= n_sat;
    end
    if (state == S_RD3) begin
      val_two <= rdata;
    end
    if (state == S_RD5) begin
      val_three <= rdata;
    end
    if (state == S_RES && out_free) begin
      out_value <= rdata;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= nhn_pkg::CNT_W'(nhn_pkg::MAX_N))
    else $error("fill count beyond table size");

  a_ptr_in_table: assert property (@(posedge clk) disable iff (rst)
    fill_count != '0 |-> nhn_pkg::CNT_W'(ptr_two) < fill_count)
    else $error("pointer outside filled table");

  a_append_grows: assert property (@(posedge clk) disable iff (rst)
    state == S_APP |=> fill_count == $past(fill_count) + nhn_pkg::CNT_W'(1))
    else $error("append did not grow the table");

  a_append_in_need: assert property (@(posedge clk) disable iff (rst)
    state == S_APP |-> fill_count < n_req)
    else $error("append past the requested index");

  a_result_ready: assert property (@(posedge clk) disable iff (rst)
    state == S_RES |-> n_req <= fill_count && n_req != '0)
    else $error("answer read from an unfilled slot");

endmodule
